/* sv/sorted_priority_queue_macros.svh */
// Assertion macros for the sorted priority queue.
// Used by the sequencer; relies on clk and rst being in scope at the use site.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`else

`define SPQ_ASSERT_IMPL(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by every module of the block.
package spq_pkg;

  // Default number of stored entries.
  localparam int SPQ_DEPTH = 8;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // Operation codes carried on the input tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } spq_status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN,
    ST_HEAD
  } spq_state_t;

  // Flags from the shared comparator.
  typedef struct packed {
    logic ge;
    logic eq;
  } spq_cmp_t;

endpackage

/* sv/sorted_priority_queue.sv */
// Sorted priority queue: up to DEPTH signed values kept in descending order.
//
// Input channel (s_*): s_tuser carries the operation (0 insert, 1 delete first
// equal entry), s_tdata the 32-bit signed value. Each input transaction yields
// exactly one result transaction on the output channel (m_*): m_tuser holds
// the status (ok, full, empty, not found), m_tdata the count after the
// operation and the head (largest value, zero when empty).
// One item is worked on at a time. The sequencer reads one entry at a time
// through the single registered memory read port, with a read state and a
// compare or write state for each entry compared or moved; then ST_FIN reads
// the head and ST_HEAD loads the result. An insert into a full queue and a
// delete from an empty one go straight to ST_FIN. s_tready returns as the
// result is loaded, so the next item can be taken while the result waits.
// A finished result waits in the output register; the block takes the next
// item meanwhile, and stalls only when a second result is ready before the
// first was taken.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// Store contents are not cleared; slots are written before they are read.
// Depends on spq_pkg, spq_seq, spq_ram and spq_cmp.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] count, [35:4] head_value, [39:36] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic signed [VALUE_W-1:0] cmp_a;
  logic signed [VALUE_W-1:0] cmp_b;
  spq_cmp_t                  cmp;
  spq_status_t               res_status;
  logic [COUNT_W-1:0]        res_count;
  logic signed [VALUE_W-1:0] res_head;

  // Sequencer and result register.
  spq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_value   (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (res_status),
    .out_count  (res_count),
    .out_head   (res_head),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp        (cmp)
  );

  // Entry store.
  spq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Shared comparator.
  spq_cmp u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .flags (cmp)
  );

  // Pack the result fields.
  assign m_tuser = res_status;
  assign m_tdata = {4'b0000, res_head, res_count};

endmodule

/* sv/spq_ram.sv */
// Entry store of the sorted priority queue: one write and one registered read per cycle.
// Depends on spq_pkg for the value width.
module spq_ram
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/spq_cmp.sv */
// Shared signed comparator used for both the insert scan and the delete search.
// Depends on spq_pkg for the value width and the flag struct.
module spq_cmp
  import spq_pkg::*;
(
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output spq_cmp_t                  flags
);

  // One magnitude compare and one equality compare.
  always_comb begin
    flags.ge = (a >= b);
    flags.eq = (a == b);
  end

endmodule

/* sv/spq_seq.sv */
// Sequencer of the sorted priority queue: walks the store one entry at a time,
// drives the memory ports and holds the result register. Depends on spq_pkg and the macros.
`include "sorted_priority_queue_macros.svh"

module spq_seq
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input transaction.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic signed [VALUE_W-1:0] in_value,
  // Result transaction.
  output logic                      out_valid,
  input  logic                      out_ready,
  output spq_status_t               out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic signed [VALUE_W-1:0] out_head,
  // Memory ports.
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic signed [VALUE_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic signed [VALUE_W-1:0] wr_data,
  // Shared comparator.
  output logic signed [VALUE_W-1:0] cmp_a,
  output logic signed [VALUE_W-1:0] cmp_b,
  input  spq_cmp_t                  cmp
);

  spq_state_t                state, state_next;
  logic [OCC_W-1:0]          occ;
  logic [OCC_W-1:0]          idx;
  logic                      op;
  logic signed [VALUE_W-1:0] val;
  spq_status_t               status;

  logic [OCC_W-1:0]          idx_inc;
  logic [OCC_W-1:0]          idx_dec;
  logic                      occ_full;
  logic                      occ_empty;
  logic                      in_accept;
  logic                      out_free;
  logic [OCC_W+COUNT_W-1:0]  occ_ext;

  assign idx_inc   = idx + 1'b1;
  assign idx_dec   = idx - 1'b1;
  assign occ_full  = (occ == OCC_W'(DEPTH));
  assign occ_empty = (occ == '0);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign occ_ext   = {{COUNT_W{1'b0}}, occ};

  // The comparator always sees the operand against the last entry read.
  assign cmp_a = val;
  assign cmp_b = rd_data;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_INSERT) begin
            state_next = occ_full ? ST_FIN : ST_INS_RD;
          end else begin
            state_next = occ_empty ? ST_FIN : ST_DEL_RD;
          end
        end
      end
      ST_INS_RD:  state_next = (idx == '0) ? ST_FIN : ST_INS_CMP;
      ST_INS_CMP: state_next = cmp.ge ? ST_INS_RD : ST_FIN;
      ST_DEL_RD:  state_next = (idx == occ) ? ST_FIN : ST_DEL_CMP;
      ST_DEL_CMP: state_next = cmp.eq ? ST_SH_RD : ST_DEL_RD;
      ST_SH_RD:   state_next = (idx_inc == occ) ? ST_FIN : ST_SH_WR;
      ST_SH_WR:   state_next = ST_SH_RD;
      ST_FIN:     state_next = ST_HEAD;
      ST_HEAD:    state_next = out_free ? ST_IDLE : ST_HEAD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = idx[AW-1:0];
    wr_data  = val;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_INS_RD: begin
        // At the head the new value lands in slot zero; else look one slot up.
        if (idx == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
        end
      end
      ST_INS_CMP: begin
        // Smaller-or-equal entries move back one slot; otherwise the value goes here.
        wr_en   = 1'b1;
        wr_data = cmp.ge ? rd_data : val;
      end
      ST_DEL_RD: begin
        rd_en = (idx != occ);
      end
      ST_SH_RD: begin
        if (idx_inc != occ) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      ST_FIN: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_DEL_CMP, ST_HEAD: begin
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_INS_RD && idx == '0) || (state == ST_INS_CMP && !cmp.ge)) begin
        occ <= occ + 1'b1;
      end else if (state == ST_SH_RD && idx_inc == occ) begin
        occ <= occ - 1'b1;
      end
    end
  end

  // Operation registers and scan index.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op  <= in_op;
          val <= in_value;
          if (in_op == OP_INSERT) begin
            idx    <= occ;
            status <= occ_full ? STAT_FULL : STAT_OK;
          end else begin
            idx    <= '0;
            status <= occ_empty ? STAT_EMPTY : STAT_OK;
          end
        end
      end
      ST_INS_CMP: begin
        if (cmp.ge) begin
          idx <= idx_dec;
        end
      end
      ST_DEL_RD: begin
        if (idx == occ) begin
          status <= STAT_NOT_FOUND;
        end
      end
      ST_DEL_CMP: begin
        if (!cmp.eq) begin
          idx <= idx_inc;
        end
      end
      ST_SH_WR: begin
        idx <= idx_inc;
      end
      ST_INS_RD, ST_SH_RD, ST_FIN, ST_HEAD: begin
      end
      default: begin
      end
    endcase
  end

  // Result register: a finished result waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HEAD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HEAD && out_free) begin
      out_status <= status;
      out_count  <= occ_ext[COUNT_W-1:0];
      out_head   <= occ_empty ? '0 : rd_data;
    end
  end

  // The fill count never passes the store depth.
  `SPQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ <= OCC_W'(DEPTH))
  // An insert into a full store leaves the count alone.
  `SPQ_ASSERT_NEXT(a_full_hold, in_accept && in_op == OP_INSERT && occ_full, $stable(occ))
  // Writes never land beyond the first free slot.
  `SPQ_ASSERT_IMPL(a_wr_range, wr_en, OCC_W'(wr_addr) <= occ)
  // The operation register does not change while an item is being worked on.
  `SPQ_ASSERT_NEXT(a_op_stable, state != ST_IDLE && state_next != ST_IDLE, $stable(op))

endmodule
